@@ rtl/core/jdc_pkg.sv @@
// jdc_pkg: shared types, calendar constants, constant-divisor helpers and tables
// for the julian day / gregorian date converter core.
// depends on nothing; imported by every jdc module.
package jdc_pkg;

	// field widths
	localparam int unsigned JD_W   = 23;
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned DAY_W  = 5;
	localparam int unsigned WDAY_W = 3;
	localparam int unsigned YDAY_W = 9;
	localparam int unsigned WEEK_W = 6;

	// operation codes
	localparam logic MODE_TO_JD   = 1'b0;
	localparam logic MODE_TO_DATE = 1'b1;

	// range limits
	localparam logic [JD_W-1:0]   JD_MIN   = 23'd1721060;
	localparam logic [JD_W-1:0]   JD_MAX   = 23'd5373484;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	// calendar constants
	localparam logic [MON_W-1:0] MON_JAN    = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB    = 4'd2;
	localparam logic [MON_W-1:0] MON_MAR    = 4'd3;
	localparam logic [MON_W-1:0] MON_DEC    = 4'd12;
	localparam logic [MON_W-1:0] MAR_SHIFT  = 4'd9;
	localparam logic [MON_W-1:0] LATE_MON   = 4'd10;
	localparam logic [14:0]      YEAR_BIAS  = 15'd4800;
	localparam logic [24:0]      JDN_OFFSET = 25'd32045;
	localparam logic [22:0]      JDN_SHIFT  = 23'd32044;
	localparam logic [22:0]      WEEK_SHIFT = 23'd31741;
	localparam logic [17:0]      DAYS_400Y  = 18'd146097;
	localparam logic [15:0]      DAYS_100Y  = 16'd36524;
	localparam logic [10:0]      DAYS_4Y    = 11'd1461;
	localparam logic [10:0]      DAYS_4Y_LAST = 11'd1460;
	localparam logic [10:0]      DAYS_Y     = 11'd365;
	localparam logic [10:0]      DAYS_2Y    = 11'd730;
	localparam logic [10:0]      DAYS_3Y    = 11'd1095;
	localparam logic [8:0]       DAYS_YEAR  = 9'd365;
	localparam logic [6:0]       CENT       = 7'd100;
	localparam logic [2:0]       DAYS_WEEK  = 3'd7;
	localparam logic [2:0]       SATURDAY   = 3'd6;

	// reciprocals: m = ceil(2^k / d) with k = input bits + ceil(log2 d),
	// exact floor quotient for every input of that width
	localparam longint unsigned R100_M   = ((64'd1 << 22) + 64'd99) / 64'd100;
	localparam longint unsigned R400A_M  = ((64'd1 << 43) + 64'd146096) / 64'd146097;
	localparam longint unsigned R4YA_M   = ((64'd1 << 31) + 64'd1460) / 64'd1461;
	localparam longint unsigned R153_M   = ((64'd1 << 19) + 64'd152) / 64'd153;
	localparam longint unsigned R7_M     = ((64'd1 << 26) + 64'd6) / 64'd7;
	localparam longint unsigned R400W_M  = ((64'd1 << 41) + 64'd146096) / 64'd146097;
	localparam longint unsigned R100Y_M  = ((64'd1 << 34) + 64'd36523) / 64'd36524;
	localparam longint unsigned R4YW_M   = ((64'd1 << 27) + 64'd1460) / 64'd1461;
	localparam longint unsigned R7S_M    = ((64'd1 << 12) + 64'd6) / 64'd7;

	// pipeline beat between stage groups
	typedef struct packed {
		logic              ok;
		logic              mode;
		logic [JD_W-1:0]   jd;
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
	} item_t;

	// finished result
	typedef struct packed {
		logic [JD_W-1:0]   julian_day;
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic [WDAY_W-1:0] week_day;
		logic [YDAY_W-1:0] year_day;
		logic [WEEK_W-1:0] year_week;
		logic              leap;
		logic              valid_res;
	} res_t;

	// x / 100, x < 2^15
	function automatic logic [8:0] div_100(input logic [14:0] x);
		logic [30:0] p;
		p = 31'(x) * 31'(R100_M);
		return p[30:22];
	endfunction

	// x / 146097, x < 2^25
	function automatic logic [7:0] div_400y_a(input logic [24:0] x);
		logic [50:0] p;
		p = 51'(x) * 51'(R400A_M);
		return p[50:43];
	endfunction

	// x / 1461, x < 2^20
	function automatic logic [9:0] div_4y_a(input logic [19:0] x);
		logic [40:0] p;
		p = 41'(x) * 41'(R4YA_M);
		return p[40:31];
	endfunction

	// x / 153, x < 2^11
	function automatic logic [3:0] div_153(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(R153_M);
		return p[22:19];
	endfunction

	// x / 7, x < 2^23
	function automatic logic [20:0] div_7(input logic [22:0] x);
		logic [46:0] p;
		p = 47'(x) * 47'(R7_M);
		return p[46:26];
	endfunction

	// x / 146097, x < 2^23
	function automatic logic [5:0] div_400y_w(input logic [22:0] x);
		logic [46:0] p;
		p = 47'(x) * 47'(R400W_M);
		return p[46:41];
	endfunction

	// x / 36524, x < 2^18
	function automatic logic [2:0] div_100y_w(input logic [17:0] x);
		logic [36:0] p;
		p = 37'(x) * 37'(R100Y_M);
		return p[36:34];
	endfunction

	// x / 1461, x < 2^16
	function automatic logic [5:0] div_4y_w(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(R4YW_M);
		return p[32:27];
	endfunction

	// x / 7, x < 2^9
	function automatic logic [6:0] div_7_small(input logic [8:0] x);
		logic [18:0] p;
		p = 19'(x) * 19'(R7S_M);
		return p[18:12];
	endfunction

	// gregorian leap rule from y mod 4, y mod 100 and (y / 100) mod 4
	function automatic logic leap_of(input logic [1:0] y_lo, input logic [6:0] rem100,
			input logic [1:0] q_lo);
		return ((y_lo == 2'd0) && (rem100 != 7'd0)) || ((rem100 == 7'd0) && (q_lo == 2'd0));
	endfunction

	// (153 * m + 2) / 5, month counted from march
	function automatic logic [8:0] mon_off(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// days before the first of the month, common year
	function automatic logic [8:0] days_before(input logic [3:0] mo);
		logic [8:0] r;
		unique case (mo)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// month length, common year
	function automatic logic [4:0] month_len(input logic [3:0] mo);
		logic [4:0] r;
		unique case (mo)
			4'd2:                          r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:       r = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
			4'd10, 4'd12:                  r = 5'd31;
			default:                       r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/jdc_front.sv @@
// jdc_front: stages 1 and 2, date check and date to day number conversion,
// range check of incoming day numbers.
// depends on jdc_pkg.
module jdc_front import jdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  logic              mode,
	input  logic [YEAR_W-1:0] in_year,
	input  logic [MON_W-1:0]  in_month,
	input  logic [DAY_W-1:0]  in_day,
	input  logic [JD_W-1:0]   in_julian_day,
	output logic              out_v,
	output item_t             out_item
);

	logic              vld_s1, vld_s2;
	logic              mode_s1;
	logic [YEAR_W-1:0] year_s1;
	logic [MON_W-1:0]  month_s1;
	logic [DAY_W-1:0]  day_s1;
	logic [JD_W-1:0]   jd_s1;
	logic [8:0]        yq_s1;
	logic [14:0]       yy_s1;
	logic [8:0]        yyq_s1;
	item_t             item_s2;

	logic        early;
	logic [14:0] yy_in;
	logic [14:0] yrem;
	logic        leap0;
	logic [4:0]  mlen;
	logic        ok0, ok1;
	logic [3:0]  mm;
	logic [24:0] jd_sum;

	// march-based year: january and february belong to the year before
	always_comb begin
		early = (in_month <= MON_FEB);
		yy_in = 15'(in_year) + YEAR_BIAS - 15'(early);
	end

	// stage 1: the two divisions by 100
	always_ff @(posedge clk) begin
		mode_s1  <= mode;
		year_s1  <= in_year;
		month_s1 <= in_month;
		day_s1   <= in_day;
		jd_s1    <= in_julian_day;
		yq_s1    <= div_100({1'b0, in_year});
		yy_s1    <= yy_in;
		yyq_s1   <= div_100(yy_in);
	end

	// leap flag and date check
	always_comb begin
		yrem  = 15'(year_s1) - 15'(yq_s1) * 15'(CENT);
		leap0 = leap_of(year_s1[1:0], yrem[6:0], yq_s1[1:0]);
		mlen  = month_len(month_s1) + 5'((month_s1 == MON_FEB) && leap0);
		ok0   = (year_s1 <= YEAR_MAX) && (month_s1 >= MON_JAN) && (month_s1 <= MON_DEC)
			&& (day_s1 != 5'd0) && (day_s1 <= mlen);
		ok1   = (jd_s1 >= JD_MIN) && (jd_s1 <= JD_MAX);
	end

	// day number sum
	always_comb begin
		mm     = (month_s1 >= MON_MAR) ? (month_s1 - MON_MAR) : (month_s1 + MAR_SHIFT);
		jd_sum = 25'(day_s1) + 25'(mon_off(mm)) + 25'(yy_s1) * 25'(DAYS_YEAR)
			+ 25'(yy_s1[14:2]) - 25'(yyq_s1) + 25'(yyq_s1[8:2]) - JDN_OFFSET;
	end

	// stage 2
	always_ff @(posedge clk) begin
		item_s2.mode  <= mode_s1;
		item_s2.ok    <= (mode_s1 == MODE_TO_DATE) ? ok1 : ok0;
		item_s2.jd    <= (mode_s1 == MODE_TO_DATE) ? jd_s1 : jd_sum[JD_W-1:0];
		item_s2.year  <= year_s1;
		item_s2.month <= month_s1;
		item_s2.day   <= day_s1;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_v;
			vld_s2 <= vld_s1;
		end
	end

	assign out_v    = vld_s2;
	assign out_item = item_s2;

endmodule

@@ rtl/core/jdc_split.sv @@
// jdc_split: stages 3 to 8, day number back to year, month and day.
// depends on jdc_pkg.
module jdc_split import jdc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_v,
	input  item_t in_item,
	output logic  out_v,
	output item_t out_item
);

	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	item_t item_s3, item_s4, item_s5, item_s6, item_s7, item_s8;
	logic [22:0] a_s3;
	logic [7:0]  b_s3, b_s4, b_s5, b_s6, b_s7;
	logic [17:0] c_s4, c_s5;
	logic [9:0]  dd_s5, dd_s6, dd_s7;
	logic [8:0]  e_s6, e_s7;
	logic [3:0]  m_s7;

	logic [22:0] a_in;
	logic [25:0] p4;
	logic [23:0] c_full;
	logic [20:0] p6;
	logic [18:0] e_full;
	logic [10:0] e5;
	logic        late;
	logic [8:0]  d_full;
	logic [3:0]  mo_calc;
	logic [15:0] y_full;
	item_t       item_nxt;

	assign a_in = in_item.jd + JDN_SHIFT;

	// 400-year cycle, day within it, 4-year cycle, day within it, march-based month
	always_comb begin
		p4     = 26'(b_s3) * 26'(DAYS_400Y);
		c_full = 24'(a_s3) - 24'(p4[25:2]);
		p6     = 21'(dd_s5) * 21'(DAYS_4Y);
		e_full = 19'(c_s5) - 19'(p6[20:2]);
		e5     = 11'({e_s6, 2'b00}) + 11'(e_s6) + 11'd2;
	end

	// final date assembly, converted date replaces the input date on day-number beats
	always_comb begin
		late    = (m_s7 >= LATE_MON);
		d_full  = e_s7 - mon_off(m_s7) + 9'd1;
		mo_calc = late ? (m_s7 - MAR_SHIFT) : (m_s7 + MON_MAR);
		y_full  = 16'(b_s7) * 16'(CENT) + 16'(dd_s7) - 16'(YEAR_BIAS) + 16'(late);
		item_nxt = item_s7;
		if (item_s7.mode == MODE_TO_DATE) begin
			item_nxt.year  = y_full[YEAR_W-1:0];
			item_nxt.month = mo_calc;
			item_nxt.day   = d_full[DAY_W-1:0];
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		item_s3 <= in_item;
		a_s3    <= a_in;
		b_s3    <= div_400y_a({a_in, 2'b11});

		item_s4 <= item_s3;
		b_s4    <= b_s3;
		c_s4    <= c_full[17:0];

		item_s5 <= item_s4;
		b_s5    <= b_s4;
		c_s5    <= c_s4;
		dd_s5   <= div_4y_a({c_s4, 2'b11});

		item_s6 <= item_s5;
		b_s6    <= b_s5;
		dd_s6   <= dd_s5;
		e_s6    <= e_full[8:0];

		item_s7 <= item_s6;
		b_s7    <= b_s6;
		dd_s7   <= dd_s6;
		e_s7    <= e_s6;
		m_s7    <= div_153(e5);

		item_s8 <= item_nxt;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s3 <= in_v;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign out_v    = vld_s8;
	assign out_item = item_s8;

endmodule

@@ rtl/core/jdc_cal.sv @@
// jdc_cal: stages 9 to 18, leap flag, day of week, day of year and week of year,
// result register with zeroing of rejected beats.
// depends on jdc_pkg.
module jdc_cal import jdc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_v,
	input  item_t in_item,
	output logic  out_v,
	output res_t  out_res
);

	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic vld_s14, vld_s15, vld_s16, vld_s17, vld_s18;
	item_t item_s9, item_s10, item_s11, item_s12, item_s13;
	item_t item_s14, item_s15, item_s16, item_s17;
	logic [8:0]  yq_s9;
	logic [20:0] wq_s9;
	logic        leap_s10, leap_s11, leap_s12, leap_s13, leap_s14, leap_s15, leap_s16, leap_s17;
	logic [2:0]  r7_s10;
	logic [22:0] t_s11;
	logic [5:0]  tq_s11;
	logic [WDAY_W-1:0] wday_s11, wday_s12, wday_s13, wday_s14, wday_s15, wday_s16, wday_s17;
	logic [YDAY_W-1:0] yday_s11, yday_s12, yday_s13, yday_s14, yday_s15, yday_s16, yday_s17;
	logic [17:0] u_s12, u_s13;
	logic [2:0]  uq_s13;
	logic [15:0] rc_s14, rc_s15;
	logic [5:0]  cq_s15;
	logic [10:0] d4_s16;
	logic [8:0]  d1_s17;
	res_t        res_s18;

	logic [14:0] yrem;
	logic [22:0] r7_full;
	logic [22:0] t_in;
	logic [23:0] u_full;
	logic [17:0] rc_full;
	logic [15:0] d4_full;
	logic        last_day;
	logic [10:0] d4_adj;
	logic [10:0] yr_base;
	logic [10:0] d1_full;
	logic [6:0]  wk_full;

	// leap flag and day number mod 7
	always_comb begin
		yrem    = 15'(item_s9.year) - 15'(yq_s9) * 15'(CENT);
		r7_full = item_s9.jd - 23'(wq_s9) * 23'(DAYS_WEEK);
	end

	// shifted day number for the week count
	assign t_in = item_s10.jd + WEEK_SHIFT - 23'(r7_s10);

	// remainders of the 400-year, 100-year and 4-year cycles
	always_comb begin
		u_full  = 24'(t_s11) - 24'(tq_s11) * 24'(DAYS_400Y);
		rc_full = u_s13 - 18'(uq_s13) * 18'(DAYS_100Y);
		d4_full = rc_s15 - 16'(cq_s15) * 16'(DAYS_4Y);
	end

	// day within the year of the 4-year cycle, last day kept in the last year
	always_comb begin
		last_day = (d4_s16 == DAYS_4Y_LAST);
		d4_adj   = d4_s16 - 11'(last_day);
		priority if (d4_adj >= DAYS_3Y) begin
			yr_base = DAYS_3Y;
		end else if (d4_adj >= DAYS_2Y) begin
			yr_base = DAYS_2Y;
		end else if (d4_adj >= DAYS_Y) begin
			yr_base = DAYS_Y;
		end else begin
			yr_base = 11'd0;
		end
		d1_full = d4_adj - yr_base + 11'(last_day);
	end

	assign wk_full = div_7_small(d1_s17) + 7'd1;

	// stage registers
	always_ff @(posedge clk) begin
		item_s9  <= in_item;
		yq_s9    <= div_100({1'b0, in_item.year});
		wq_s9    <= div_7(in_item.jd);

		item_s10 <= item_s9;
		leap_s10 <= leap_of(item_s9.year[1:0], yrem[6:0], yq_s9[1:0]);
		r7_s10   <= r7_full[2:0];

		item_s11 <= item_s10;
		leap_s11 <= leap_s10;
		t_s11    <= t_in;
		tq_s11   <= div_400y_w(t_in);
		wday_s11 <= (r7_s10 == SATURDAY) ? 3'd0 : (r7_s10 + 3'd1);
		yday_s11 <= days_before(item_s10.month) + 9'(item_s10.day)
			+ 9'(leap_s10 && (item_s10.month > MON_FEB));

		item_s12 <= item_s11;
		leap_s12 <= leap_s11;
		wday_s12 <= wday_s11;
		yday_s12 <= yday_s11;
		u_s12    <= u_full[17:0];

		item_s13 <= item_s12;
		leap_s13 <= leap_s12;
		wday_s13 <= wday_s12;
		yday_s13 <= yday_s12;
		u_s13    <= u_s12;
		uq_s13   <= div_100y_w(u_s12);

		item_s14 <= item_s13;
		leap_s14 <= leap_s13;
		wday_s14 <= wday_s13;
		yday_s14 <= yday_s13;
		rc_s14   <= rc_full[15:0];

		item_s15 <= item_s14;
		leap_s15 <= leap_s14;
		wday_s15 <= wday_s14;
		yday_s15 <= yday_s14;
		rc_s15   <= rc_s14;
		cq_s15   <= div_4y_w(rc_s14);

		item_s16 <= item_s15;
		leap_s16 <= leap_s15;
		wday_s16 <= wday_s15;
		yday_s16 <= yday_s15;
		d4_s16   <= d4_full[10:0];

		item_s17 <= item_s16;
		leap_s17 <= leap_s16;
		wday_s17 <= wday_s16;
		yday_s17 <= yday_s16;
		d1_s17   <= d1_full[8:0];

		// result register, all zero for a rejected beat
		if (item_s17.ok) begin
			res_s18.julian_day <= item_s17.jd;
			res_s18.year       <= item_s17.year;
			res_s18.month      <= item_s17.month;
			res_s18.day        <= item_s17.day;
			res_s18.week_day   <= wday_s17;
			res_s18.year_day   <= yday_s17;
			res_s18.year_week  <= wk_full[WEEK_W-1:0];
			res_s18.leap       <= leap_s17;
			res_s18.valid_res  <= 1'b1;
		end else begin
			res_s18 <= '0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
		end else begin
			vld_s9  <= in_v;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
			vld_s17 <= vld_s16;
			vld_s18 <= vld_s17;
		end
	end

	assign out_v   = vld_s18;
	assign out_res = res_s18;

endmodule

@@ rtl/core/julian_day_date_converter_core.sv @@
// Julian day number / Gregorian date converter. Fully pipelined: one beat is taken
// in every clock cycle (busy is always low) and its result comes out of the last stage,
// marked by done for exactly one cycle; the 18 stages come from the chain of
// constant-divisor multiplies and their remainders, cut so that a stage holds at most
// a couple of constant multiplies. The receiver cannot stall
// the pipeline, so it must take every result in the cycle that done is high.
// depends on jdc_pkg, jdc_front, jdc_split, jdc_cal.
module julian_day_date_converter_core import jdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [YEAR_W-1:0] in_year,
	input  logic [MON_W-1:0]  in_month,
	input  logic [DAY_W-1:0]  in_day,
	input  logic [JD_W-1:0]   in_julian_day,
	output logic              done,
	output logic [JD_W-1:0]   julian_day,
	output logic [YEAR_W-1:0] out_year,
	output logic [MON_W-1:0]  out_month,
	output logic [DAY_W-1:0]  out_day,
	output logic [WDAY_W-1:0] week_day,
	output logic [YDAY_W-1:0] year_day,
	output logic [WEEK_W-1:0] year_week,
	output logic              leap,
	output logic              valid_res
);

	logic  front_v, split_v, cal_v;
	item_t front_item, split_item;
	res_t  res;

	// never stalls
	assign busy = 1'b0;

	jdc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_v          (start && !busy),
		.mode          (mode),
		.in_year       (in_year),
		.in_month      (in_month),
		.in_day        (in_day),
		.in_julian_day (in_julian_day),
		.out_v         (front_v),
		.out_item      (front_item)
	);

	jdc_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (front_v),
		.in_item  (front_item),
		.out_v    (split_v),
		.out_item (split_item)
	);

	jdc_cal u_cal (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (split_v),
		.in_item (split_item),
		.out_v   (cal_v),
		.out_res (res)
	);

	// result ports
	assign done       = cal_v;
	assign julian_day = res.julian_day;
	assign out_year   = res.year;
	assign out_month  = res.month;
	assign out_day    = res.day;
	assign week_day   = res.week_day;
	assign year_day   = res.year_day;
	assign year_week  = res.year_week;
	assign leap       = res.leap;
	assign valid_res  = res.valid_res;

endmodule
